[design/spkt_pkg.sv]
// Package for the sorted pair key table: widths, request and status codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package spkt_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = 27;
	localparam int ID_W = 14;
	localparam int PAY_W = 128;
	localparam int ENT_W = KEY_W + PAY_W;
	localparam int OUT_CNT_W = 11;
	localparam logic [ID_W-1:0] ID_MAX = 14'd9999;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_ORDERED = 2'd1;
	localparam logic [1:0] REQ_CANON = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FOUND = 3'd1;
	localparam logic [2:0] ST_MISS = 3'd2;
	localparam logic [2:0] ST_REJECT = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	function automatic logic id_ok(input logic [ID_W-1:0] v);
		id_ok = (v != '0) && (v <= ID_MAX);
	endfunction

	// a*10000 + b as shifts and adds: 10000 = 8192+1024+512+256+16
	function automatic logic [KEY_W-1:0] make_key(input logic [ID_W-1:0] a,
			input logic [ID_W-1:0] b);
		logic [KEY_W-1:0] x;
		x = KEY_W'(a);
		make_key = (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4) + KEY_W'(b);
	endfunction
endpackage

[design/spkt_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module spkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[design/sorted_pair_key_table.sv]
// Sorted pair key table top level: sequencer, shared comparator and table RAM.
// Depends on spkt_pkg and spkt_ram.
`timescale 1ns / 1ps
// One request is taken at a time; the input is not ready until the result
// has been taken. A lookup runs a binary search; each probe of the table RAM
// is an address state, then a registered read and key compare. An ordered
// lookup may try the swapped pair as a second search. An insert searches
// first, then shifts the entries above the insertion point up by one, each
// entry read and then written one slot higher. Clear only zeroes the count,
// with no clearing pass: only entries below the held count are ever used.
module sorted_pair_key_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[1:0], path_key[28:2], first_station[42:29], second_station[56:43],
	// payload_word_a[88:57], b[120:89], c[152:121], d[184:153], zero fill
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], found_reversed[3], found_key[30:4], out_word_a[62:31],
	// b[94:63], c[126:95], d[158:127], entry_count[169:159], zero fill
	output logic [175:0] m_tdata
);
	localparam int IW = spkt_pkg::IDX_W;
	localparam int CW = spkt_pkg::CNT_W;
	localparam int KW = spkt_pkg::KEY_W;
	localparam int EW = spkt_pkg::ENT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_RD = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_WR = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;
	localparam logic [2:0] S_RD_MV = 3'd7;

	logic [2:0] state_q;
	logic [1:0] req_q;
	logic [KW-1:0] key_q, alt_q;
	logic alt_ok_q, second_q;
	logic [spkt_pkg::PAY_W-1:0] pay_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, mv_q;
	logic [175:0] out_q;

	logic ram_we;
	logic [IW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	spkt_ram #(.WIDTH(EW), .DEPTH(spkt_pkg::TABLE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic [1:0] in_req;
	logic [KW-1:0] in_key;
	logic [spkt_pkg::ID_W-1:0] in_a, in_b, c_lo, c_hi;
	logic in_okab, in_okba;
	assign in_req = s_tdata[1:0];
	assign in_key = s_tdata[28:2];
	assign in_a = s_tdata[42:29];
	assign in_b = s_tdata[56:43];
	assign in_okab = spkt_pkg::id_ok(in_a) && spkt_pkg::id_ok(in_b);
	assign in_okba = in_okab;
	assign c_lo = (in_a <= in_b) ? in_a : in_b;
	assign c_hi = (in_a <= in_b) ? in_b : in_a;

	logic [CW-1:0] mid;
	logic [CW:0] mid_sum;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CW:1];
	logic rd_key_lt, rd_key_eq;
	assign rd_key_lt = ram_rdata[EW-1 -: KW] < key_q;
	assign rd_key_eq = ram_rdata[EW-1 -: KW] == key_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = out_q;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = mid[IW-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			// mid equals lo once the search has closed
			S_PROBE: ram_addr = mid[IW-1:0];
			S_RD_MV: ram_addr = IW'(mv_q - CW'(1));
			S_MOVE: begin
				ram_addr = mv_q[IW-1:0];
				ram_we = 1'b1;
			end
			S_WR: begin
				ram_addr = lo_q[IW-1:0];
				ram_we = 1'b1;
				ram_wdata = {key_q, pay_q};
			end
			default: ram_addr = mid[IW-1:0];
		endcase
	end

	function automatic logic [175:0] pack(input logic [2:0] st, input logic rev,
			input logic [EW-1:0] ent, input logic [CW-1:0] cnt);
		pack = '0;
		pack[2:0] = st;
		pack[3] = rev;
		pack[30:4] = ent[EW-1 -: KW];
		pack[158:31] = ent[spkt_pkg::PAY_W-1:0];
		pack[169:159] = spkt_pkg::OUT_CNT_W'(cnt);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					req_q <= in_req;
					pay_q <= s_tdata[184:57];
					lo_q <= '0;
					hi_q <= cnt_q;
					second_q <= 1'b0;
					alt_q <= spkt_pkg::make_key(in_b, in_a);
					alt_ok_q <= in_okba && (in_a != in_b);
					if (in_req == spkt_pkg::REQ_CANON)
						key_q <= spkt_pkg::make_key(c_lo, c_hi);
					else
						key_q <= spkt_pkg::make_key(in_a, in_b);
					unique case (in_req)
						spkt_pkg::REQ_CLEAR: begin
							cnt_q <= '0;
							out_q <= pack(spkt_pkg::ST_OK, 1'b0, '0, '0);
							state_q <= S_OUT;
						end
						spkt_pkg::REQ_INSERT: begin
							if (!in_okab || in_a > in_b ||
									spkt_pkg::make_key(in_a, in_b) != in_key) begin
								out_q <= pack(spkt_pkg::ST_REJECT, 1'b0, '0, cnt_q);
								state_q <= S_OUT;
							end else state_q <= S_PROBE;
						end
						default: begin
							if (in_okab) state_q <= S_PROBE;
							else if (in_req == spkt_pkg::REQ_ORDERED) begin
								out_q <= pack(spkt_pkg::ST_MISS, 1'b0, '0, cnt_q);
								state_q <= S_OUT;
							end else begin
								out_q <= pack(spkt_pkg::ST_MISS, 1'b0, '0, cnt_q);
								state_q <= S_OUT;
							end
						end
					endcase
				end
				S_PROBE: begin
					// search done when lo == hi; otherwise compare at mid
					if (lo_q < hi_q) state_q <= S_CMP;
					else state_q <= S_RD;
				end
				S_CMP: begin
					if (rd_key_lt) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= S_PROBE;
				end
				S_RD: begin
					// ram_rdata holds entry at lo (valid only if lo < count)
					if (req_q == spkt_pkg::REQ_INSERT) begin
						if (lo_q < cnt_q && rd_key_eq) begin
							out_q <= pack(spkt_pkg::ST_REJECT, 1'b0, '0, cnt_q);
							state_q <= S_OUT;
						end else if (cnt_q >= CW'(spkt_pkg::TABLE_DEPTH)) begin
							out_q <= pack(spkt_pkg::ST_FULL, 1'b0, '0, cnt_q);
							state_q <= S_OUT;
						end else begin
							mv_q <= cnt_q;
							state_q <= (cnt_q > lo_q) ? S_RD_MV : S_WR;
						end
					end else if (lo_q < cnt_q && rd_key_eq) begin
						out_q <= pack(spkt_pkg::ST_FOUND, second_q, ram_rdata, cnt_q);
						state_q <= S_OUT;
					end else if (req_q == spkt_pkg::REQ_ORDERED && !second_q && alt_ok_q) begin
						second_q <= 1'b1;
						key_q <= alt_q;
						lo_q <= '0;
						hi_q <= cnt_q;
						state_q <= S_PROBE;
					end else begin
						out_q <= pack(spkt_pkg::ST_MISS, 1'b0, '0, cnt_q);
						state_q <= S_OUT;
					end
				end
				// reads entry mv-1
				S_RD_MV: state_q <= S_MOVE;
				S_MOVE: begin
					// writes entry mv-1 (read last cycle) into slot mv
					mv_q <= mv_q - CW'(1);
					if (mv_q - CW'(1) > lo_q) state_q <= S_RD_MV;
					else state_q <= S_WR;
				end
				S_WR: begin
					cnt_q <= cnt_q + CW'(1);
					out_q <= pack(spkt_pkg::ST_OK, 1'b0, '0, cnt_q + CW'(1));
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
